// ===== rtl/bth_pkg.sv =====
// boundary tag heap allocator: shared types and constants
// datapath operation codes, status flags and operation codes of the request word
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bth_pkg;

  localparam int REQ_W  = 6;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 8;
  localparam int PTR_W  = 8;
  localparam int SIZE_W = 7;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  localparam logic [DATA_W-1:0] TAG_FREE_MASK = 8'hFE;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_CAPTURE,
    OP_A_READ,
    OP_A_EVAL,
    OP_A_MARK,
    OP_A_INC,
    OP_A_SPLIT0,
    OP_A_SPLIT1,
    OP_A_SPLIT2,
    OP_A_SPLIT3,
    OP_WRITE,
    OP_F_CHK,
    OP_F_HD,
    OP_F_FT,
    OP_F_NX,
    OP_F_SWEEP,
    OP_B_CHK,
    OP_B_RD1,
    OP_B_RD2,
    OP_B_SWEEP,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic init_last;
    logic ptr_in;
    logic fit;
    logic size_zero;
    logic small_rest;
    logic addr_zero;
    logic hd_out;
    logic ft_out;
    logic ft_last;
    logic rd_free;
    logic nf_in;
    logic sweep_end;
    logic hd_zero;
    logic nh_ok;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/bth_req_if.sv =====
// request channel of the heap allocator: valid/ready plus operation fields
// depends on bth_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface bth_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic [bth_pkg::REQ_W-1:0]    request_size;
  logic [bth_pkg::ADDR_W-1:0]   address;
  logic [bth_pkg::DATA_W-1:0]   write_data;

  modport source (output valid, func, request_size, address, write_data, input ready);
  modport sink (input valid, func, request_size, address, write_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bth_rsp_if.sv =====
// response channel of the heap allocator: valid/ready plus grant fields
// depends on bth_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface bth_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         granted;
  logic [bth_pkg::ADDR_W-1:0]   payload_address;

  modport source (output valid, granted, payload_address, input ready);
  modport sink (input valid, granted, payload_address, output ready);
endinterface

`default_nettype wire

// ===== rtl/bth_dpath.sv =====
// heap allocator datapath: byte store, walk pointer, tag and sweep registers
// carries out one bth_pkg::dp_op_t per cycle and reports bth_pkg::dp_status_t
`timescale 1ns / 1ps
`default_nettype none

module bth_dpath #(
  parameter int HEAP_BYTES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bth_pkg::dp_op_t                  op,
  input  logic [bth_pkg::REQ_W-1:0]        request_size,
  input  logic [bth_pkg::ADDR_W-1:0]       address,
  input  logic [bth_pkg::DATA_W-1:0]       write_data,
  output bth_pkg::dp_status_t              status,
  output logic                             granted,
  output logic [bth_pkg::ADDR_W-1:0]       payload_address
);

  localparam int IW = $clog2(HEAP_BYTES);
  localparam logic [bth_pkg::PTR_W-1:0] HEAP_END  = bth_pkg::PTR_W'(HEAP_BYTES);
  localparam logic [bth_pkg::PTR_W-1:0] HEAP_LAST = bth_pkg::PTR_W'(HEAP_BYTES - 1);
  localparam logic [bth_pkg::DATA_W-1:0] TAG_INIT = bth_pkg::DATA_W'((HEAP_BYTES * 2) % 256);

  function automatic logic [bth_pkg::SIZE_W-1:0] span_of(
    input logic [bth_pkg::SIZE_W-1:0] s
  );
    return (s >= 7'd2) ? s - 7'd2 : 7'd0;
  endfunction

  logic [bth_pkg::DATA_W-1:0] mem [HEAP_BYTES];
  logic [bth_pkg::DATA_W-1:0] rdata;

  logic [bth_pkg::REQ_W-1:0]  sz_r;
  logic [bth_pkg::ADDR_W-1:0] addr_r;
  logic [bth_pkg::DATA_W-1:0] wdat_r;
  logic [bth_pkg::PTR_W-1:0]  ptr;
  logic [bth_pkg::PTR_W-1:0]  ft;
  logic [bth_pkg::PTR_W-1:0]  k;
  logic [bth_pkg::PTR_W-1:0]  lim;
  logic [bth_pkg::DATA_W-1:0] tag;
  logic [bth_pkg::DATA_W-1:0] merged;
  logic [bth_pkg::SIZE_W-1:0] hsize;
  logic [bth_pkg::SIZE_W-1:0] psize;
  logic                       grant;

  logic [bth_pkg::SIZE_W-1:0] rsize, tsize, hsz, rest;
  logic [bth_pkg::SIZE_W-1:0] sum_f, sum_b, span_f, span_b;
  logic [bth_pkg::PTR_W-1:0]  fidx, fhd, ft_calc, nf, nh;
  logic [bth_pkg::DATA_W-1:0] merged_f, merged_b, used, left, sweep_data;

  logic                       we, re;
  logic [bth_pkg::PTR_W-1:0]  waddr, raddr;
  logic [bth_pkg::DATA_W-1:0] wdata;

  assign rsize    = rdata[7:1];
  assign tsize    = tag[7:1];
  assign hsz      = {1'b0, sz_r} + 7'd2;
  assign rest     = tsize - hsz;
  assign used     = {hsz, 1'b1};
  assign left     = {rest, 1'b0};
  assign fidx     = ptr + {1'b0, tsize} - 8'd1;
  assign fhd      = {2'b00, addr_r - 6'd1};
  assign ft_calc  = ptr + {1'b0, rsize} - 8'd1;
  assign sum_f    = rsize + hsize;
  assign merged_f = {sum_f, 1'b0};
  assign span_f   = span_of(sum_f);
  assign nf       = ptr + 8'd1 + {1'b0, span_f};
  assign sum_b    = psize + rsize;
  assign merged_b = {sum_b, 1'b0};
  assign span_b   = span_of(sum_b);
  assign nh       = ft - 8'd1 - {1'b0, span_b};
  assign sweep_data = (k == lim) ? merged : '0;

  always_comb begin
    status.init_last  = (k == HEAP_LAST);
    status.ptr_in     = (ptr < HEAP_END);
    status.fit        = !rdata[0] && (rsize >= hsz);
    status.size_zero  = (rsize == '0);
    status.small_rest = (rest <= 7'd2);
    status.addr_zero  = (addr_r == '0);
    status.hd_out     = (fhd >= HEAP_END);
    status.ft_out     = (ft_calc >= HEAP_END);
    status.ft_last    = (ft >= HEAP_LAST);
    status.rd_free    = !rdata[0];
    status.nf_in      = (nf < HEAP_END);
    status.sweep_end  = (k == lim);
    status.hd_zero    = (ptr == '0);
    status.nh_ok      = (ft >= 8'd1 + {1'b0, span_b});
  end

  // store port selection
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = '0;
    case (op)
      bth_pkg::OP_INIT: begin
        we    = 1'b1;
        waddr = k;
        wdata = (k == '0 || k == HEAP_LAST) ? TAG_INIT : '0;
      end
      bth_pkg::OP_A_READ: begin
        re    = 1'b1;
        raddr = ptr;
      end
      bth_pkg::OP_A_MARK: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = tag | 8'd1;
        re    = 1'b1;
        raddr = fidx;
      end
      bth_pkg::OP_A_INC: begin
        we    = 1'b1;
        waddr = fidx;
        wdata = rdata + 8'd1;
      end
      bth_pkg::OP_A_SPLIT0: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = used;
      end
      bth_pkg::OP_A_SPLIT1: begin
        we    = 1'b1;
        waddr = ptr + {1'b0, hsz} - 8'd1;
        wdata = used;
      end
      bth_pkg::OP_A_SPLIT2: begin
        we    = 1'b1;
        waddr = ptr + {1'b0, hsz};
        wdata = left;
      end
      bth_pkg::OP_A_SPLIT3: begin
        we    = 1'b1;
        waddr = fidx;
        wdata = left;
      end
      bth_pkg::OP_WRITE: begin
        we    = 1'b1;
        waddr = {2'b00, addr_r};
        wdata = wdat_r;
      end
      bth_pkg::OP_F_CHK: begin
        re    = 1'b1;
        raddr = fhd;
      end
      bth_pkg::OP_F_HD: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = rdata & bth_pkg::TAG_FREE_MASK;
        re    = 1'b1;
        raddr = ft_calc;
      end
      bth_pkg::OP_F_FT: begin
        we    = 1'b1;
        waddr = ft;
        wdata = rdata & bth_pkg::TAG_FREE_MASK;
        re    = 1'b1;
        raddr = ft + 8'd1;
      end
      bth_pkg::OP_F_NX: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = merged_f;
      end
      bth_pkg::OP_F_SWEEP, bth_pkg::OP_B_SWEEP: begin
        we    = 1'b1;
        waddr = k;
        wdata = sweep_data;
      end
      bth_pkg::OP_B_CHK: begin
        re    = 1'b1;
        raddr = ptr - 8'd1;
      end
      bth_pkg::OP_B_RD1: begin
        re    = 1'b1;
        raddr = ft;
      end
      bth_pkg::OP_B_RD2: begin
        we    = 1'b1;
        waddr = ft;
        wdata = merged_b;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // byte store, registered read, old data on a colliding read
  always_ff @(posedge clk) begin
    if (we && waddr < HEAP_END) begin
      mem[waddr[IW-1:0]] <= wdata;
    end
    if (re && raddr < HEAP_END) begin
      rdata <= mem[raddr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= '0;
      grant <= 1'b0;
    end else begin
      case (op)
        bth_pkg::OP_INIT: begin
          k <= k + 8'd1;
        end
        bth_pkg::OP_CAPTURE: begin
          sz_r   <= request_size;
          addr_r <= address;
          wdat_r <= write_data;
          ptr    <= '0;
          grant  <= 1'b0;
        end
        bth_pkg::OP_A_EVAL: begin
          tag <= rdata;
          if (status.fit) begin
            grant <= 1'b1;
          end else begin
            ptr <= ptr + {1'b0, rsize};
          end
        end
        bth_pkg::OP_F_CHK: begin
          ptr <= fhd;
        end
        bth_pkg::OP_F_HD: begin
          hsize <= rsize;
          ft    <= ft_calc;
        end
        bth_pkg::OP_F_NX: begin
          merged <= merged_f;
          k      <= ptr + 8'd1;
          lim    <= nf;
          ft     <= nf;
        end
        bth_pkg::OP_F_SWEEP: begin
          k <= k + 8'd1;
        end
        bth_pkg::OP_B_RD1: begin
          psize <= rsize;
        end
        bth_pkg::OP_B_RD2: begin
          merged <= merged_b;
          k      <= ft - 8'd1;
          lim    <= nh;
        end
        bth_pkg::OP_B_SWEEP: begin
          k <= k - 8'd1;
        end
        bth_pkg::OP_OUT: begin
          granted         <= grant;
          payload_address <= grant ? ptr[5:0] + 6'd1 : '0;
        end
        default: begin
          k <= k;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bth_ctrl.sv =====
// heap allocator controller: one-hot sequencer for allocate, free and write
// drives bth_pkg::dp_op_t into the datapath and owns the handshake flags
`timescale 1ns / 1ps
`default_nettype none

module bth_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [1:0]          req_func,
  input  logic                rsp_ready,
  input  bth_pkg::dp_status_t status,
  output logic                req_ready,
  output logic                rsp_valid,
  output bth_pkg::dp_op_t     op
);

  typedef enum logic [19:0] {
    S_INIT   = 20'h00001,
    S_IDLE   = 20'h00002,
    S_A_RD   = 20'h00004,
    S_A_EV   = 20'h00008,
    S_A_FIT  = 20'h00010,
    S_A_INC  = 20'h00020,
    S_A_S1   = 20'h00040,
    S_A_S2   = 20'h00080,
    S_A_S3   = 20'h00100,
    S_WR     = 20'h00200,
    S_F_CHK  = 20'h00400,
    S_F_HD   = 20'h00800,
    S_F_FT   = 20'h01000,
    S_F_NX   = 20'h02000,
    S_F_ZERO = 20'h04000,
    S_B_CHK  = 20'h08000,
    S_B_RD1  = 20'h10000,
    S_B_RD2  = 20'h20000,
    S_B_ZERO = 20'h40000,
    S_FIN    = 20'h80000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    op         = bth_pkg::OP_NONE;
    case (state)
      S_INIT: begin
        op = bth_pkg::OP_INIT;
        if (status.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          op = bth_pkg::OP_CAPTURE;
          case (req_func)
            bth_pkg::FUNC_ALLOC: state_next = S_A_RD;
            bth_pkg::FUNC_FREE:  state_next = S_F_CHK;
            bth_pkg::FUNC_WRITE: state_next = S_WR;
            default:             state_next = S_FIN;
          endcase
        end
      end
      S_A_RD: begin
        if (status.ptr_in) begin
          op         = bth_pkg::OP_A_READ;
          state_next = S_A_EV;
        end else begin
          state_next = S_FIN;
        end
      end
      S_A_EV: begin
        op = bth_pkg::OP_A_EVAL;
        if (status.fit) begin
          state_next = S_A_FIT;
        end else if (status.size_zero) begin
          state_next = S_FIN;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_A_FIT: begin
        if (status.small_rest) begin
          op         = bth_pkg::OP_A_MARK;
          state_next = S_A_INC;
        end else begin
          op         = bth_pkg::OP_A_SPLIT0;
          state_next = S_A_S1;
        end
      end
      S_A_INC: begin
        op         = bth_pkg::OP_A_INC;
        state_next = S_FIN;
      end
      S_A_S1: begin
        op         = bth_pkg::OP_A_SPLIT1;
        state_next = S_A_S2;
      end
      S_A_S2: begin
        op         = bth_pkg::OP_A_SPLIT2;
        state_next = S_A_S3;
      end
      S_A_S3: begin
        op         = bth_pkg::OP_A_SPLIT3;
        state_next = S_FIN;
      end
      S_WR: begin
        op         = bth_pkg::OP_WRITE;
        state_next = S_FIN;
      end
      S_F_CHK: begin
        if (status.addr_zero || status.hd_out) begin
          state_next = S_FIN;
        end else begin
          op         = bth_pkg::OP_F_CHK;
          state_next = S_F_HD;
        end
      end
      S_F_HD: begin
        if (status.size_zero || status.ft_out) begin
          state_next = S_FIN;
        end else begin
          op         = bth_pkg::OP_F_HD;
          state_next = S_F_FT;
        end
      end
      S_F_FT: begin
        op         = bth_pkg::OP_F_FT;
        state_next = status.ft_last ? S_B_CHK : S_F_NX;
      end
      S_F_NX: begin
        if (status.rd_free && status.nf_in) begin
          op         = bth_pkg::OP_F_NX;
          state_next = S_F_ZERO;
        end else begin
          state_next = S_B_CHK;
        end
      end
      S_F_ZERO: begin
        op = bth_pkg::OP_F_SWEEP;
        if (status.sweep_end) state_next = S_B_CHK;
      end
      S_B_CHK: begin
        if (status.hd_zero) begin
          state_next = S_FIN;
        end else begin
          op         = bth_pkg::OP_B_CHK;
          state_next = S_B_RD1;
        end
      end
      S_B_RD1: begin
        if (status.rd_free) begin
          op         = bth_pkg::OP_B_RD1;
          state_next = S_B_RD2;
        end else begin
          state_next = S_FIN;
        end
      end
      S_B_RD2: begin
        if (status.nh_ok) begin
          op         = bth_pkg::OP_B_RD2;
          state_next = S_B_ZERO;
        end else begin
          state_next = S_FIN;
        end
      end
      S_B_ZERO: begin
        op = bth_pkg::OP_B_SWEEP;
        if (status.sweep_end) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          op         = bth_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/boundary_tag_heap_allocator.sv =====
// boundary tag heap allocator top level: first-fit allocate, coalescing free, raw byte write
// joins bth_ctrl and bth_dpath; uses bth_pkg, bth_req_if and bth_rsp_if
//
//   channel  role    word
//   req      sink    func, request_size, address, write_data
//   rsp      source  granted, payload_address
//
// allocate reads and checks one block tag at a time; free clears both tags, then merges forward and backward,
// the coalescing zero sweeps take one byte a cycle; write stores one byte, a no-op only returns a response
// the byte store has a single write and a single read port
// after reset a clearing pass writes the end tags and zeros every other byte before req.ready rises
// a result waits in the output register; a stalled rsp holds the next result only
`timescale 1ns / 1ps
`default_nettype none

module boundary_tag_heap_allocator #(
  parameter int HEAP_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst,
  bth_req_if.sink   req,
  bth_rsp_if.source rsp
);

  bth_pkg::dp_op_t     op;
  bth_pkg::dp_status_t status;

  bth_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .rsp_ready (rsp.ready),
    .status    (status),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .op        (op)
  );

  bth_dpath #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .request_size    (req.request_size),
    .address         (req.address),
    .write_data      (req.write_data),
    .status          (status),
    .granted         (rsp.granted),
    .payload_address (rsp.payload_address)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_boundary_tag_heap_allocator.sv =====
// self-checking bench for boundary_tag_heap_allocator: directed tag cases, then random
// allocate/free/write traffic, checked against a tracked copy of the byte heap
// depends on bth_pkg, bth_req_if and bth_rsp_if from the rtl
`timescale 1ns / 1ps

module tb_boundary_tag_heap_allocator;

  localparam int HEAP_BYTES = 64;
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int RANDOM_WORDS = 1050;
  localparam int RESTORE_EVERY = 220;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic                       granted;
    logic [bth_pkg::ADDR_W-1:0] payload_address;
  } grant_t;

  class heap_grant_board;
    logic [bth_pkg::DATA_W-1:0] heap_image [HEAP_BYTES];
    grant_t            expected_grants [$];
    int                live_payloads [$];
    int                mismatches;

    function new();
      foreach (heap_image[k]) heap_image[k] = '0;
      heap_image[0] = 8'((HEAP_BYTES << 1) & 255);
      heap_image[HEAP_BYTES-1] = 8'((HEAP_BYTES << 1) & 255);
      mismatches = 0;
    endfunction

    function int tag_rd(int idx);
      if (idx < 0 || idx >= HEAP_BYTES) return 0;
      return int'(heap_image[idx]);
    endfunction

    function void tag_wr(int idx, int v);
      if (idx < 0 || idx >= HEAP_BYTES) return;
      heap_image[idx] = 8'(v);
    endfunction

    function int size_of(int idx);
      return tag_rd(idx) >> 1;
    endfunction

    function bit is_free(int idx);
      return (tag_rd(idx) & 1) == 0;
    endfunction

    // first-fit walk from byte 0, marks or splits the block found, returns header index or -1
    function int first_fit(int want);
      int  i;
      int  v;
      int  sz;
      int  rest;
      int  hsz;
      bit  found;
      i = 0;
      found = 1'b0;
      while (i < HEAP_BYTES) begin
        v = int'(heap_image[i]);
        sz = v >> 1;
        if ((v & 1) == 0 && sz - 2 >= want) begin
          found = 1'b1;
          break;
        end
        if (sz == 0) break;
        i += sz;
      end
      if (!found) return -1;
      sz = size_of(i);
      rest = sz - want - 2;
      if (rest <= 2) begin
        heap_image[i] = heap_image[i] | 8'h01;
        tag_wr(i + sz - 1, tag_rd(i + sz - 1) + 1);
      end else begin
        hsz = want + 2;
        tag_wr(i, (hsz << 1) + 1);
        tag_wr(i + hsz - 1, (hsz << 1) + 1);
        tag_wr(i + hsz, rest << 1);
        tag_wr(i + sz - 1, rest << 1);
      end
      return i;
    endfunction

    function void release_block(int addr);
      int hd;
      int sz;
      int ft;
      int merged;
      int span;
      int nf;
      int nh;
      if (addr == 0) return;
      hd = addr - 1;
      if (hd >= HEAP_BYTES) return;
      sz = size_of(hd);
      if (sz == 0) return;
      ft = hd + sz - 1;
      if (ft >= HEAP_BYTES) return;
      heap_image[hd] = heap_image[hd] & bth_pkg::TAG_FREE_MASK;
      heap_image[ft] = heap_image[ft] & bth_pkg::TAG_FREE_MASK;
      // coalesce forward
      if (ft < HEAP_BYTES - 1 && is_free(ft + 1)) begin
        merged = ((size_of(ft + 1) + size_of(hd)) << 1) & 255;
        span = (merged >> 1) - 2 > 0 ? (merged >> 1) - 2 : 0;
        nf = hd + 1 + span;
        if (nf < HEAP_BYTES) begin
          heap_image[hd] = 8'(merged);
          for (int k = hd + 1; k < nf; k++) heap_image[k] = '0;
          heap_image[nf] = 8'(merged);
          ft = nf;
        end
      end
      // coalesce backward
      if (hd > 0 && is_free(hd - 1)) begin
        merged = ((size_of(hd - 1) + size_of(ft)) << 1) & 255;
        span = (merged >> 1) - 2 > 0 ? (merged >> 1) - 2 : 0;
        nh = ft - 1 - span;
        if (nh >= 0) begin
          heap_image[ft] = 8'(merged);
          for (int k = ft - 1; k > nh; k--) heap_image[k] = '0;
          heap_image[nh] = 8'(merged);
        end
      end
    endfunction

    function void note_request(logic [1:0] op, logic [bth_pkg::REQ_W-1:0] want,
                               logic [bth_pkg::ADDR_W-1:0] addr,
                               logic [bth_pkg::DATA_W-1:0] data);
      grant_t g;
      int     hd;
      g = '0;
      case (op)
        bth_pkg::FUNC_ALLOC: begin
          hd = first_fit(int'(want));
          if (hd >= 0) begin
            g.granted = 1'b1;
            g.payload_address = bth_pkg::ADDR_W'(hd + 1);
            live_payloads.push_back(int'(g.payload_address));
          end
        end
        bth_pkg::FUNC_FREE: begin
          release_block(int'(addr));
          for (int k = 0; k < live_payloads.size(); k++) begin
            if (live_payloads[k] == int'(addr)) begin
              live_payloads.delete(k);
              break;
            end
          end
        end
        bth_pkg::FUNC_WRITE: tag_wr(int'(addr), int'(data));
        default: ;
      endcase
      expected_grants.push_back(g);
    endfunction

    function void check_grant(logic granted, logic [bth_pkg::ADDR_W-1:0] payload_address);
      grant_t want;
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word granted=%0d payload_address=%0d",
                   $realtime, granted, payload_address);
        return;
      end
      want = expected_grants.pop_front();
      if (want.granted !== granted || want.payload_address !== payload_address) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch granted exp %0d got %0d, payload_address exp %0d got %0d",
                   $realtime, want.granted, granted, want.payload_address, payload_address);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  bth_req_if req_ch ();
  bth_rsp_if rsp_ch ();

  boundary_tag_heap_allocator #(.HEAP_BYTES(HEAP_BYTES)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  heap_grant_board board;
  int issued_words;
  int results_seen;
  int cycle_count;
  bit steady;
  bit hold_on;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_word(input logic [1:0] op, input int want, input int addr,
                           input int data);
    while (!(steady || hold_on) && $urandom_range(0, 99) < 27) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= op;
    req_ch.request_size <= bth_pkg::REQ_W'(want);
    req_ch.address <= bth_pkg::ADDR_W'(addr);
    req_ch.write_data <= bth_pkg::DATA_W'(data);
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    board.note_request(op, bth_pkg::REQ_W'(want), bth_pkg::ADDR_W'(addr),
                       bth_pkg::DATA_W'(data));
    issued_words++;
    steady = (issued_words >= 600 && issued_words < 800);
  endtask

  // rewrite the whole heap to its reset image
  task automatic restore_heap();
    for (int k = 0; k < HEAP_BYTES; k++)
      send_word(bth_pkg::FUNC_WRITE, $urandom_range(0, 62), k,
                (k == 0 || k == HEAP_BYTES - 1) ? ((HEAP_BYTES << 1) & 255) : 0);
    board.live_payloads.delete();
  endtask

  task automatic random_traffic();
    int roll;
    int since_restore;
    int pick;
    int sz_roll;
    since_restore = 0;
    while (issued_words < RANDOM_WORDS) begin
      roll = $urandom_range(0, 99);
      if (since_restore >= RESTORE_EVERY) begin
        restore_heap();
        since_restore = 0;
      end else begin
        since_restore++;
        if (roll < 45 || (roll < 80 && board.live_payloads.size() == 0)) begin
          sz_roll = $urandom_range(0, 99);
          send_word(bth_pkg::FUNC_ALLOC,
                    sz_roll < 80 ? $urandom_range(0, 6) :
                    sz_roll < 95 ? $urandom_range(0, 20) : $urandom_range(0, 62),
                    $urandom_range(0, 63), $urandom_range(0, 255));
        end else if (roll < 80) begin
          pick = $urandom_range(0, board.live_payloads.size() - 1);
          send_word(bth_pkg::FUNC_FREE, $urandom_range(0, 62), board.live_payloads[pick],
                    $urandom_range(0, 255));
        end else if (roll < 88) begin
          send_word(bth_pkg::FUNC_FREE, $urandom_range(0, 62), $urandom_range(0, 63),
                    $urandom_range(0, 255));
        end else if (roll < 95) begin
          send_word(bth_pkg::FUNC_WRITE, $urandom_range(0, 62), $urandom_range(0, 63),
                    $urandom_range(0, 255));
        end else begin
          send_word(FUNC_NONE, $urandom_range(0, 62), $urandom_range(0, 63),
                    $urandom_range(0, 255));
        end
      end
    end
  endtask

  // response side: random back-pressure plus one long hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        board.check_grant(rsp_ch.granted, rsp_ch.payload_address);
        results_seen++;
      end
      if (results_seen == HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_on = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
      end else begin
        rsp_ch.ready <= (steady || hold_on) ? 1'b1 : ($urandom_range(0, 99) >= 27);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    board = new();
    issued_words = 0;
    results_seen = 0;
    steady = 1'b0;
    hold_on = 1'b0;
    hold_done = 1'b0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.func <= bth_pkg::FUNC_ALLOC;
    req_ch.request_size <= '0;
    req_ch.address <= '0;
    req_ch.write_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // split, miss, forward merge past the end, restore by merging
    send_word(bth_pkg::FUNC_ALLOC, 0, 5, 0);
    send_word(bth_pkg::FUNC_ALLOC, 62, 0, 0);
    send_word(bth_pkg::FUNC_WRITE, 62, 2, 250);
    send_word(bth_pkg::FUNC_FREE, 0, 1, 255);
    send_word(bth_pkg::FUNC_WRITE, 0, 2, 124);
    send_word(bth_pkg::FUNC_FREE, 0, 1, 0);
    // whole heap taken, full heap miss, bad frees, then a real free of the whole heap
    send_word(bth_pkg::FUNC_ALLOC, 60, 0, 0);
    send_word(bth_pkg::FUNC_ALLOC, 0, 0, 0);
    send_word(bth_pkg::FUNC_FREE, 0, 0, 0);
    send_word(bth_pkg::FUNC_FREE, 0, 63, 0);
    send_word(bth_pkg::FUNC_FREE, 0, 1, 0);
    // grant on the last byte wraps the payload address
    send_word(bth_pkg::FUNC_WRITE, 0, 0, 126);
    send_word(bth_pkg::FUNC_ALLOC, 62, 0, 0);
    send_word(bth_pkg::FUNC_WRITE, 0, 63, 128);
    send_word(bth_pkg::FUNC_WRITE, 0, 0, 128);
    send_word(FUNC_NONE, 63, 63, 255);
    // two blocks, then free both with backward merge
    send_word(bth_pkg::FUNC_ALLOC, 3, 0, 0);
    send_word(bth_pkg::FUNC_ALLOC, 5, 0, 0);
    send_word(bth_pkg::FUNC_FREE, 0, 1, 0);
    send_word(bth_pkg::FUNC_FREE, 0, 6, 0);
    send_word(bth_pkg::FUNC_WRITE, 0, 45, 8'hA5);
    send_word(bth_pkg::FUNC_WRITE, 0, 45, 8'h5A);
    send_word(bth_pkg::FUNC_WRITE, 0, 45, 0);
    board.live_payloads.delete();

    random_traffic();
    req_ch.valid <= 1'b0;

    while (board.expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.expected_grants.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
